>>> hdl/hufd_pkg.sv
// Package for the Huffman tree bit decoder.
// Holds table size, field widths, stream packing and the node record type.
// No dependencies.
package hufd_pkg;

    localparam int NODE_COUNT = 512;
    localparam int NODE_AW    = $clog2(NODE_COUNT);

    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 4;
    localparam int TRASH_W = 3;

    // s_axis_tdata layout, lowest bit first
    localparam int ADDR_LO  = 0;
    localparam int LEFT_LO  = ADDR_LO + IDX_W;
    localparam int RIGHT_LO = LEFT_LO + IDX_W;
    localparam int LEAF_LO  = RIGHT_LO + IDX_W;
    localparam int SYM_LO   = LEAF_LO + 1;
    localparam int BYTE_LO  = SYM_LO + SYM_W;
    localparam int IN_USED_W  = BYTE_LO + BYTE_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SYM_W + 7) / 8) * 8;

    localparam logic OP_NODE_WR = 1'b0;
    localparam logic OP_DECODE  = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } t_node;

endpackage

>>> hdl/huffman_tree_bit_decoder.sv
// Huffman tree bit decoder: node table in a RAM, walked one bit per cycle unless the output stalls.
// Depends on hufd_pkg.
//
// Items on s_axis are node writes (tuser 0) or compressed bytes (tuser 1),
// tlast marking the final byte of a stream, whose low trash_bits bits are
// padding. A byte is shifted out MSB first, one bit per cycle while the output
// does not stall, each bit doing one dependent read of the node RAM (single
// read port, registered data); no new input is taken until the byte is done.
// Symbols leave on m_axis, tlast marking the last symbol of a byte; a byte
// that ends no code gives nothing. The user must write a node before it is
// read, so the RAM needs no clearing after reset; the block itself does not
// enforce this. trash_bits is to be set on the cfg channel only while the
// decoder is idle; the block itself does not enforce this.
module huffman_tree_bit_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cfg: trash_bits
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hufd_pkg::TRASH_W-1:0]     i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_addr, left_child, right_child, is_leaf, leaf_symbol, data_byte, zero pad
    input  logic [hufd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [0:0]                       s_axis_tuser,
    // final_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // symbol
    output logic [hufd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // last_of_byte
    output logic                             m_axis_tlast
);
    import hufd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FLUSH} t_state;

    t_state             r_state;
    logic [BYTE_W-1:0]  r_sh;
    logic [CNT_W-1:0]   r_left;
    logic               r_chk;
    logic               r_fin;
    logic [TRASH_W-1:0] r_trash;
    t_node              r_cur;
    logic [IDX_W-1:0]   r_pos;
    t_node              r_root;
    t_node              r_mem_q;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_oob;
    logic               r_pend_v;
    logic [SYM_W-1:0]   r_pend_sym;
    logic               r_out_v;
    logic [SYM_W-1:0]   r_out_sym;
    logic               r_out_last;

    t_node r_node_mem [NODE_COUNT];

    logic             w_acc;
    logic             w_op;
    logic [IDX_W-1:0] w_addr;
    logic             w_addr_ok;
    t_node            w_rec;
    logic             w_wr;
    t_node            w_child;
    logic             w_hit;
    t_node            w_cur_rec;
    logic [IDX_W-1:0] w_cur_pos;
    logic [IDX_W-1:0] w_next_idx;
    logic             w_out_free;
    logic             w_adv;
    logic             w_issue;
    logic [CNT_W-1:0] w_stop;

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_op      = s_axis_tuser[0];
    assign w_addr    = s_axis_tdata[ADDR_LO +: IDX_W];
    assign w_addr_ok = 32'(w_addr) < NODE_COUNT;
    assign w_rec.left  = s_axis_tdata[LEFT_LO +: IDX_W];
    assign w_rec.right = s_axis_tdata[RIGHT_LO +: IDX_W];
    assign w_rec.leaf  = s_axis_tdata[LEAF_LO];
    assign w_rec.sym   = s_axis_tdata[SYM_LO +: SYM_W];
    assign w_wr      = w_acc && (w_op == OP_NODE_WR) && w_addr_ok;
    assign w_stop    = s_axis_tlast ? CNT_W'(r_trash) : '0;

    // child word registered by the last read; off-table index reads as an empty inner node
    assign w_child   = r_oob ? '0 : r_mem_q;
    assign w_hit     = r_chk && w_child.leaf;

    always_comb begin
        if (!r_chk) begin
            w_cur_rec = r_cur;
            w_cur_pos = r_pos;
        end else if (w_hit) begin
            w_cur_rec = r_root;
            w_cur_pos = '0;
        end else begin
            w_cur_rec = w_child;
            w_cur_pos = r_rd_idx;
        end
    end

    assign w_next_idx = r_sh[BYTE_W-1] ? w_cur_rec.right : w_cur_rec.left;
    assign w_out_free = !r_out_v || m_axis_tready;
    assign w_adv      = (r_state == ST_WALK) && (!w_hit || !r_pend_v || w_out_free);
    assign w_issue    = w_adv && (r_left != '0);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_node_mem[NODE_AW'(w_addr)] <= w_rec;
        end
        if (w_issue) begin
            r_mem_q <= r_node_mem[NODE_AW'(w_next_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_trash  <= '0;
            r_pos    <= '0;
            r_chk    <= 1'b0;
            r_fin    <= 1'b0;
            r_left   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_trash <= i_cfg_data;
            end
            if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (w_op == OP_NODE_WR) begin
                            if (w_addr_ok) begin
                                if (w_addr == '0) begin
                                    r_root <= w_rec;
                                end
                                if (w_addr == r_pos) begin
                                    r_cur <= w_rec;
                                end
                            end
                        end else begin
                            r_sh    <= s_axis_tdata[BYTE_LO +: BYTE_W];
                            r_left  <= CNT_W'(BYTE_W) - w_stop;
                            r_fin   <= s_axis_tlast;
                            r_chk   <= 1'b0;
                            r_state <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (w_adv) begin
                        if (w_hit) begin
                            if (r_pend_v) begin
                                r_out_v    <= 1'b1;
                                r_out_sym  <= r_pend_sym;
                                r_out_last <= 1'b0;
                            end
                            r_pend_v   <= 1'b1;
                            r_pend_sym <= w_child.sym;
                        end
                        if (r_left != '0) begin
                            r_sh     <= r_sh << 1;
                            r_left   <= r_left - CNT_W'(1);
                            r_chk    <= 1'b1;
                            r_rd_idx <= w_next_idx;
                            r_oob    <= 32'(w_next_idx) >= NODE_COUNT;
                        end else begin
                            r_cur   <= r_fin ? r_root : w_cur_rec;
                            r_pos   <= r_fin ? '0 : w_cur_pos;
                            r_chk   <= 1'b0;
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_sym  <= r_pend_sym;
                        r_out_last <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_sym);
    assign m_axis_tlast  = r_out_last;

    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("held symbol left behind at end of byte");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_left <= CNT_W'(BYTE_W)))
        else $error("bit count out of range");

    a_final_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_fin) |-> (r_pos == '0))
        else $error("walk not back at root after final byte");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while walking");

endmodule
